FILE: src/i2cm_pkg.sv
package i2cm_pkg;

	localparam int DELAY_WIDTH_DEF = 16;
	localparam int TICKS_W         = 16;
	localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd15;

	// command codes on the operation field
	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_STOP  = 3'd2;
	localparam logic [2:0] OP_WRITE = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	// register index on the config port
	localparam logic REG_DELAY_TICKS = 1'b0;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       scl_in;
		logic       sda_in;
	} i2cm_item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       nack_error;
	} i2cm_res_t;

endpackage

FILE: src/i2cm_seq.sv
module i2cm_seq #(
	parameter int DELAY_WIDTH = i2cm_pkg::DELAY_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  i2cm_pkg::i2cm_item_t              item,
	input  logic [i2cm_pkg::TICKS_W-1:0]      delay_ticks,
	output i2cm_pkg::i2cm_res_t               res
);
	import i2cm_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_FIN,
		S_ST0, S_ST1, S_ST2, S_ST3, S_ST4,
		S_SP0, S_SP1, S_SP2, S_SP3,
		S_TX0, S_TX1, S_TX2, S_TX3, S_TX4, S_TX5, S_TX6, S_TX7,
		S_RX0, S_RX1, S_RX2, S_RX3, S_RX4, S_RX5, S_RX6, S_RX7
	} seq_state_t;

	seq_state_t             state_q;
	logic [3:0]             bit_cnt_q;
	logic [7:0]             shift_q;
	logic [DELAY_WIDTH-1:0] dly_q;
	logic                   ack_q;
	logic                   scl_q;
	logic                   sda_q;
	logic                   done_q;
	logic [7:0]             rx_hold_q;
	logic                   nack_q;

	logic [DELAY_WIDTH-1:0] dly_load;
	logic [3:0]             bit_cnt_inc;

	assign dly_load    = DELAY_WIDTH'(delay_ticks);
	assign bit_cnt_inc = bit_cnt_q + 4'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			bit_cnt_q <= '0;
			shift_q   <= '0;
			dly_q     <= '0;
			ack_q     <= 1'b0;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
			done_q    <= 1'b0;
			rx_hold_q <= '0;
			nack_q    <= 1'b0;
		end else if (step) begin
			done_q <= 1'b0;
			if (state_q == S_IDLE) begin
				unique case (item.operation)
					OP_START: begin
						bit_cnt_q <= '0;
						dly_q     <= '0;
						state_q   <= S_ST0;
					end
					OP_STOP: begin
						bit_cnt_q <= '0;
						dly_q     <= '0;
						state_q   <= S_SP0;
					end
					OP_WRITE: begin
						bit_cnt_q <= '0;
						dly_q     <= '0;
						shift_q   <= item.tx_byte;
						nack_q    <= 1'b0;
						state_q   <= S_TX0;
					end
					OP_READ: begin
						bit_cnt_q <= '0;
						dly_q     <= '0;
						ack_q     <= item.send_ack;
						shift_q   <= '0;
						state_q   <= S_RX0;
					end
					default: ;
				endcase
			end else if (dly_q != '0) begin
				dly_q <= dly_q - 1'b1;
			end else begin
				unique case (state_q)
					S_FIN: begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
					// start: release both, then sda low while scl high, then scl low
					S_ST0: begin sda_q <= 1'b1; dly_q <= dly_load; state_q <= S_ST1; end
					S_ST1: begin scl_q <= 1'b1; dly_q <= dly_load; state_q <= S_ST2; end
					S_ST2: begin sda_q <= 1'b0; dly_q <= dly_load; state_q <= S_ST3; end
					S_ST3: begin scl_q <= 1'b0; dly_q <= dly_load; state_q <= S_ST4; end
					S_ST4: begin dly_q <= dly_load; state_q <= S_FIN; end
					// stop: sda low, scl up, sda up
					S_SP0: begin dly_q <= dly_load; state_q <= S_SP1; end
					S_SP1: begin sda_q <= 1'b0; dly_q <= dly_load; state_q <= S_SP2; end
					S_SP2: begin scl_q <= 1'b1; dly_q <= dly_load; state_q <= S_SP3; end
					S_SP3: begin sda_q <= 1'b1; dly_q <= dly_load; state_q <= S_FIN; end
					// write, msb first
					S_TX0: begin
						sda_q   <= shift_q[7];
						shift_q <= {shift_q[6:0], 1'b0};
						dly_q   <= dly_load;
						state_q <= S_TX1;
					end
					S_TX1: begin scl_q <= 1'b1; dly_q <= dly_load; state_q <= S_TX2; end
					S_TX2: begin
						scl_q     <= 1'b0;
						bit_cnt_q <= bit_cnt_inc;
						state_q   <= (bit_cnt_inc >= 4'd8) ? S_TX3 : S_TX0;
					end
					S_TX3: begin dly_q <= dly_load; state_q <= S_TX4; end
					S_TX4: begin dly_q <= dly_load; state_q <= S_TX5; end
					S_TX5: begin sda_q <= 1'b1; dly_q <= dly_load; state_q <= S_TX6; end
					S_TX6: begin scl_q <= 1'b1; dly_q <= dly_load; state_q <= S_TX7; end
					S_TX7: begin
						// ack slot: high sda means nack, finish with a stop
						scl_q <= 1'b0;
						dly_q <= dly_load;
						if (item.sda_in) begin
							nack_q  <= 1'b1;
							state_q <= S_SP0;
						end else begin
							state_q <= S_FIN;
						end
					end
					// read
					S_RX0: begin sda_q <= 1'b1; state_q <= S_RX1; end
					S_RX1: begin scl_q <= 1'b1; dly_q <= dly_load; state_q <= S_RX2; end
					S_RX2: begin
						// hold here while the slave stretches scl
						if (item.scl_in) begin
							shift_q   <= {shift_q[6:0], item.sda_in};
							scl_q     <= 1'b0;
							dly_q     <= dly_load;
							bit_cnt_q <= bit_cnt_inc;
							state_q   <= (bit_cnt_inc >= 4'd8) ? S_RX3 : S_RX1;
						end
					end
					S_RX3: begin dly_q <= dly_load; state_q <= S_RX4; end
					S_RX4: begin sda_q <= ~ack_q; state_q <= S_RX5; end
					S_RX5: begin scl_q <= 1'b1; dly_q <= dly_load; state_q <= S_RX6; end
					S_RX6: begin scl_q <= 1'b0; dly_q <= dly_load; state_q <= S_RX7; end
					S_RX7: begin
						sda_q     <= 1'b1;
						rx_hold_q <= shift_q;
						state_q   <= S_FIN;
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign res.scl_out    = scl_q;
	assign res.sda_out    = sda_q;
	assign res.busy_res   = (state_q != S_IDLE);
	assign res.done_res   = done_q;
	assign res.rx_byte    = rx_hold_q;
	assign res.nack_error = nack_q;

endmodule

FILE: src/i2c_master_byte_engine_top.sv
// channel   dir  tdata fields (lsb first)                                    tuser  tlast
// s_axis    in   operation[2:0] tx_byte[10:3] send_ack[11] scl_in[12]        -      -
//                sda_in[13], zero fill to 16
// m_axis    out  scl_out[0] sda_out[1] busy_res[2] done_res[3] rx_byte[11:4] -      -
//                nack_error[12], zero fill to 16
// apb       cfg  delay_ticks at byte address 0 (pwdata[15:0])
//
// one request is one tick of the bus sequencer; one result per request
// a request is registered, then the sequencer advances one step and its state is the result
// a result leaves via the input register, then the sequencer state; requests are taken
// every clock unless m_axis stalls, as set by the single sequencer step per request;
// stalls on m_axis freeze both stages and drop s_tready in the same cycle
// arst_n clears the pipeline and puts the sequencer idle with both lines released
module i2c_master_byte_engine_top #(
	parameter int DELAY_WIDTH = i2cm_pkg::DELAY_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // operation, tx_byte, send_ack, scl_in, sda_in
	// stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // scl_out, sda_out, busy_res, done_res, rx_byte, nack_error
	// config
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import i2cm_pkg::*;

	logic                 adv;           // whole pipeline moves this cycle
	logic                 vld_s1;
	i2cm_item_t           item_s1;
	logic                 out_vld_q;
	logic [TICKS_W-1:0]   delay_ticks_q;
	i2cm_res_t            res;

	assign adv      = !out_vld_q || m_tready;
	assign s_tready = adv;

	// config register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_ticks_q <= TICKS_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_DELAY_TICKS) begin
			delay_ticks_q <= pwdata[TICKS_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_DELAY_TICKS) ? {{(32-TICKS_W){1'b0}}, delay_ticks_q} : '0;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s_tvalid) begin
			item_s1.operation <= s_tdata[2:0];
			item_s1.tx_byte   <= s_tdata[10:3];
			item_s1.send_ack  <= s_tdata[11];
			item_s1.scl_in    <= s_tdata[12];
			item_s1.sda_in    <= s_tdata[13];
		end
	end

	// sequencer state doubles as the result register
	i2cm_seq #(
		.DELAY_WIDTH (DELAY_WIDTH)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv && vld_s1),
		.item        (item_s1),
		.delay_ticks (delay_ticks_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s1;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {3'b000, res.nack_error, res.rx_byte, res.done_res,
		res.busy_res, res.sda_out, res.scl_out};

endmodule

FILE: src/i2cm_chk.sv
module i2cm_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// a completing tick always leaves the engine idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> !m_tdata[2])
		else $error("done with busy still set");

	// done never shows on two results in a row
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tdata[3] |=> !(m_tvalid && m_tdata[3]))
		else $error("done held over two ticks");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed under stall");

	// input side is open whenever the output side is free
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("request blocked with output free");

endmodule

bind i2c_master_byte_engine_top i2cm_chk u_chk (.*);
